FILE: hw/rtl/owusf_pkg.sv
package owusf_pkg;

    localparam logic [1:0] CMD_BEGIN   = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_ECHO    = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [1:0] KIND_SLOT   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_RXBYTE = 2'd2;

    localparam logic [7:0] RESET_FRAME   = 8'hF0;
    localparam logic [7:0] ONE_FRAME     = 8'hFF;
    localparam logic [7:0] ZERO_FRAME    = 8'h00;
    localparam logic [7:0] SKIP_ROM      = 8'hCC;
    localparam logic [7:0] ST_NOT_CONN   = 8'h01;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_CONN
    } t_phase;

    typedef enum logic [1:0] {
        OP_SINGLE,
        OP_BYTE,
        OP_PRESENT
    } t_op;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       fast_baud;
        logic       last;
    } t_res;

    typedef struct packed {
        t_op        op;
        logic [1:0] kind;
        logic [7:0] value;
        logic       fast;
    } t_job;

endpackage

FILE: hw/rtl/owusf_front.sv
module owusf_front #(
    parameter int SLOTS_PER_BYTE = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  owusf_pkg::t_req  i_req,
    output logic             o_push,
    output owusf_pkg::t_job  o_job
);

    localparam int RCW = (SLOTS_PER_BYTE > 1) ? $clog2(SLOTS_PER_BYTE) : 1;
    localparam logic [RCW-1:0] RC_LAST = RCW'(SLOTS_PER_BYTE - 1);

    owusf_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_cmd, n_cmd;
    logic [7:0]        r_shift, n_shift;
    logic [RCW-1:0]    r_cnt, n_cnt;
    logic [7:0]        w_rx_byte;

    assign w_rx_byte = r_shift |
        ((i_req.data == owusf_pkg::ONE_FRAME) ? (8'd1 << r_cnt) : 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owusf_pkg::PH_IDLE;
            r_cmd   <= '0;
            r_shift <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        if (i_accept) begin
            case (i_req.cmd)
                owusf_pkg::CMD_BEGIN: begin
                    n_cmd   = i_req.data;
                    n_shift = '0;
                    n_cnt   = '0;
                    n_phase = owusf_pkg::PH_WAIT;
                end
                owusf_pkg::CMD_ECHO: begin
                    if (r_phase == owusf_pkg::PH_WAIT) begin
                        n_phase = (i_req.data != owusf_pkg::RESET_FRAME) ?
                                  owusf_pkg::PH_CONN : owusf_pkg::PH_IDLE;
                    end
                end
                owusf_pkg::CMD_READ: begin
                    if (r_phase == owusf_pkg::PH_CONN) begin
                        if (r_cnt == RC_LAST) begin
                            n_shift = '0;
                            n_cnt   = '0;
                        end else begin
                            n_shift = w_rx_byte;
                            n_cnt   = r_cnt + RCW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // job classification
    always_comb begin
        o_push = 1'b0;
        o_job  = '{op: owusf_pkg::OP_SINGLE, kind: owusf_pkg::KIND_SLOT,
                   value: owusf_pkg::RESET_FRAME, fast: 1'b0};
        if (i_accept) begin
            case (i_req.cmd)
                owusf_pkg::CMD_BEGIN: begin
                    o_push = 1'b1;
                end
                owusf_pkg::CMD_PAYLOAD: begin
                    if (r_phase == owusf_pkg::PH_CONN) begin
                        o_push = 1'b1;
                        o_job  = '{op: owusf_pkg::OP_BYTE, kind: owusf_pkg::KIND_SLOT,
                                   value: i_req.data, fast: 1'b1};
                    end
                end
                owusf_pkg::CMD_ECHO: begin
                    if (r_phase == owusf_pkg::PH_WAIT) begin
                        o_push = 1'b1;
                        if (i_req.data != owusf_pkg::RESET_FRAME) begin
                            o_job = '{op: owusf_pkg::OP_PRESENT,
                                      kind: owusf_pkg::KIND_SLOT,
                                      value: r_cmd, fast: 1'b1};
                        end else begin
                            o_job = '{op: owusf_pkg::OP_SINGLE,
                                      kind: owusf_pkg::KIND_STATUS,
                                      value: owusf_pkg::ST_NOT_CONN, fast: 1'b0};
                        end
                    end
                end
                owusf_pkg::CMD_READ: begin
                    if (r_phase == owusf_pkg::PH_CONN && r_cnt == RC_LAST) begin
                        o_push = 1'b1;
                        o_job  = '{op: owusf_pkg::OP_SINGLE,
                                   kind: owusf_pkg::KIND_RXBYTE,
                                   value: w_rx_byte, fast: 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/owusf_queue.sv
module owusf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  owusf_pkg::t_job  i_job,
    input  logic             i_pop,
    output owusf_pkg::t_job  o_head,
    output logic             o_empty,
    output logic             o_full
);

    localparam int AW = $clog2(owusf_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(owusf_pkg::QUEUE_DEPTH + 1);

    owusf_pkg::t_job r_mem [owusf_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push, w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(owusf_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr    = w_push ? r_wr + AW'(1) : r_wr;
        n_rd    = w_pop ? r_rd + AW'(1) : r_rd;
        n_count = r_count + CW'(w_push) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: hw/rtl/owusf_back.sv
module owusf_back #(
    parameter int SLOTS_PER_BYTE = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  owusf_pkg::t_job  i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output owusf_pkg::t_res  o_res
);

    localparam int SW = $clog2(2 * SLOTS_PER_BYTE);
    localparam logic [SW-1:0] S_BYTE = SW'(SLOTS_PER_BYTE);
    localparam logic [SW-1:0] END_BYTE = SW'(SLOTS_PER_BYTE - 1);
    localparam logic [SW-1:0] END_PRES = SW'(2 * SLOTS_PER_BYTE - 1);

    logic [SW-1:0]   r_slot, n_slot;
    logic            r_valid, n_valid;
    owusf_pkg::t_res r_res, n_res;
    logic            w_load, w_fire, w_sec, w_end;
    logic [2:0]      w_idx;
    logic [7:0]      w_byte;
    owusf_pkg::t_res w_res;

    assign w_load  = !r_valid || i_ready;
    assign w_fire  = w_load && !i_empty;
    assign w_sec   = (r_slot >= S_BYTE);
    assign w_idx   = 3'(w_sec ? r_slot - S_BYTE : r_slot);
    assign w_byte  = (i_head.op == owusf_pkg::OP_PRESENT && !w_sec) ?
                     owusf_pkg::SKIP_ROM : i_head.value;
    assign o_pop   = w_fire && w_end;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        case (i_head.op)
            owusf_pkg::OP_BYTE:    w_end = (r_slot == END_BYTE);
            owusf_pkg::OP_PRESENT: w_end = (r_slot == END_PRES);
            default:               w_end = 1'b1;
        endcase
    end

    always_comb begin
        if (i_head.op == owusf_pkg::OP_SINGLE) begin
            w_res = '{kind: i_head.kind, value: i_head.value,
                      fast_baud: i_head.fast, last: 1'b1};
        end else begin
            w_res = '{kind: owusf_pkg::KIND_SLOT,
                      value: w_byte[w_idx] ? owusf_pkg::ONE_FRAME : owusf_pkg::ZERO_FRAME,
                      fast_baud: 1'b1, last: w_end};
        end
    end

    always_comb begin
        n_slot  = r_slot;
        n_valid = r_valid;
        n_res   = r_res;
        if (w_fire) begin
            n_valid = 1'b1;
            n_res   = w_res;
            n_slot  = w_end ? '0 : r_slot + SW'(1);
        end else if (w_load) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

FILE: hw/rtl/one_wire_uart_slot_framer.sv
// channel   signals                     payload
// request   i_valid / o_ready / i_req   t_req {cmd, data}
// result    o_valid / i_ready / o_res   t_res {kind, value, fast_baud, last}
//
// A request is taken whenever the job queue (4 deep) has room.
// The result sequencer emits one result per cycle while a job is queued and the output is not stalled: 1 for begin,
// status or a received byte, SLOTS_PER_BYTE for a payload byte, 2*SLOTS_PER_BYTE on presence.
// Requests that produce no result queue nothing.
// Synchronous active-low reset clears phase, read assembly, queue and output.
// A stalled output holds its result; the front keeps taking requests until the
// queue fills.
module one_wire_uart_slot_framer #(
    parameter int SLOTS_PER_BYTE = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  owusf_pkg::t_req  i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output owusf_pkg::t_res  o_res
);

    logic            w_accept, w_push, w_pop, w_empty, w_full;
    owusf_pkg::t_job w_job, w_head;

    assign o_ready  = !w_full;
    assign w_accept = i_valid && o_ready;

    owusf_front #(
        .SLOTS_PER_BYTE(SLOTS_PER_BYTE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (i_req),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    owusf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    owusf_back #(
        .SLOTS_PER_BYTE(SLOTS_PER_BYTE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_AT   = 150;   // requests sent before the sender waits for a drain
    localparam int HOLD_AT    = 200;   // results seen before the long receiver hold-off
    localparam int HOLD_LEN   = 300;
    localparam int TAIL       = 64;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    owusf_pkg::t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    owusf_pkg::t_res o_res;

    one_wire_uart_slot_framer #(
        .SLOTS_PER_BYTE(SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_res  (o_res)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // bus master shadow state
    owusf_pkg::t_phase link_phase = owusf_pkg::PH_IDLE;
    logic [7:0] held_cmd   = '0;
    logic [7:0] rx_bits    = '0;
    logic [3:0] rx_taken   = '0;

    owusf_pkg::t_req pending_reqs[$];
    owusf_pkg::t_res frames_due[$];

    int  n_sent     = 0;
    int  n_total    = 0;
    int  n_seen     = 0;
    int  n_bad      = 0;
    int  n_cycles   = 0;
    int  send_gap   = 0;
    int  recv_gap   = 0;
    bit  send_calm  = 1'b0;
    bit  recv_calm  = 1'b0;

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 29) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic void due(logic [1:0] kind, logic [7:0] value, logic fast, logic last);
        frames_due.push_back('{kind: kind, value: value, fast_baud: fast, last: last});
    endfunction

    function automatic void due_slots(logic [7:0] b, logic final_byte);
        for (int i = 0; i < SLOTS; i++)
            due(owusf_pkg::KIND_SLOT,
                b[i] ? owusf_pkg::ONE_FRAME : owusf_pkg::ZERO_FRAME, 1'b1,
                final_byte && (i == SLOTS - 1));
    endfunction

    function automatic void fold_request(owusf_pkg::t_req rq);
        case (rq.cmd)
            owusf_pkg::CMD_BEGIN: begin
                held_cmd   = rq.data;
                rx_bits    = '0;
                rx_taken   = '0;
                link_phase = owusf_pkg::PH_WAIT;
                due(owusf_pkg::KIND_SLOT, owusf_pkg::RESET_FRAME, 1'b0, 1'b1);
            end
            owusf_pkg::CMD_PAYLOAD: begin
                if (link_phase == owusf_pkg::PH_CONN)
                    due_slots(rq.data, 1'b1);
            end
            owusf_pkg::CMD_ECHO: begin
                if (link_phase == owusf_pkg::PH_WAIT) begin
                    if (rq.data != owusf_pkg::RESET_FRAME) begin
                        due_slots(owusf_pkg::SKIP_ROM, 1'b0);
                        due_slots(held_cmd, 1'b1);
                        link_phase = owusf_pkg::PH_CONN;
                    end else begin
                        due(owusf_pkg::KIND_STATUS, owusf_pkg::ST_NOT_CONN, 1'b0, 1'b1);
                        link_phase = owusf_pkg::PH_IDLE;
                    end
                end
            end
            owusf_pkg::CMD_READ: begin
                if (link_phase == owusf_pkg::PH_CONN) begin
                    if (rq.data == owusf_pkg::ONE_FRAME)
                        rx_bits[rx_taken[2:0]] = 1'b1;
                    rx_taken = rx_taken + 4'd1;
                    if (rx_taken >= SLOTS) begin
                        due(owusf_pkg::KIND_RXBYTE, rx_bits, 1'b1, 1'b1);
                        rx_bits  = '0;
                        rx_taken = '0;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add(logic [1:0] cmd, logic [7:0] data);
        pending_reqs.push_back('{cmd: cmd, data: data});
    endfunction

    // request driver
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_req   <= '0;
        end else begin
            offer = i_valid;
            if (i_valid && o_ready) begin
                fold_request(i_req);
                n_sent++;
                offer    = 1'b0;
                send_gap = draw_gap(send_calm);
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0
                             && !(n_sent == DRAIN_AT && frames_due.size() != 0)) begin
                    i_req <= pending_reqs.pop_front();
                    offer = 1'b1;
                end
            end
            i_valid <= offer;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        bit take;
        owusf_pkg::t_res want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            take = i_ready;
            if (o_valid && i_ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got kind %0d value %02h",
                             $time, o_res.kind, o_res.value);
                    n_bad++;
                end else begin
                    want = frames_due.pop_front();
                    if (o_res !== want) begin
                        $display("%0t: expected kind %0d value %02h fast %0d last %0d",
                                 $time, want.kind, want.value, want.fast_baud, want.last);
                        $display("%0t:   actual kind %0d value %02h fast %0d last %0d",
                                 $time, o_res.kind, o_res.value, o_res.fast_baud,
                                 o_res.last);
                        n_bad++;
                    end
                end
                n_seen++;
                take     = 1'b0;
                recv_gap = (n_seen == HOLD_AT) ? HOLD_LEN : draw_gap(recv_calm);
            end
            if (!take) begin
                if (recv_gap > 0)
                    recv_gap--;
                else
                    take = 1'b1;
            end
            i_ready <= take;
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_CAP) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        int   pick;
        int   ops;
        int   frames;
        logic [7:0] echo;

        // directed
        add(owusf_pkg::CMD_READ, owusf_pkg::ONE_FRAME);     // ignored while idle
        add(owusf_pkg::CMD_PAYLOAD, 8'hFF);                 // ignored while idle
        add(owusf_pkg::CMD_ECHO, 8'h00);                    // echo with no reset pending
        add(owusf_pkg::CMD_BEGIN, 8'h00);
        add(owusf_pkg::CMD_ECHO, owusf_pkg::RESET_FRAME);   // nobody on the bus
        add(owusf_pkg::CMD_PAYLOAD, 8'h55);
        add(owusf_pkg::CMD_BEGIN, 8'hFF);
        add(owusf_pkg::CMD_ECHO, 8'h00);                    // presence
        add(owusf_pkg::CMD_ECHO, 8'h00);                    // stray echo while connected
        add(owusf_pkg::CMD_PAYLOAD, 8'h00);
        add(owusf_pkg::CMD_PAYLOAD, 8'hFF);
        add(owusf_pkg::CMD_PAYLOAD, 8'hA5);
        add(owusf_pkg::CMD_READ, 8'hFF);
        add(owusf_pkg::CMD_READ, 8'h00);
        add(owusf_pkg::CMD_READ, 8'hFE);
        add(owusf_pkg::CMD_READ, 8'hFF);
        add(owusf_pkg::CMD_READ, 8'h7F);
        add(owusf_pkg::CMD_READ, 8'hFF);
        add(owusf_pkg::CMD_READ, 8'h01);
        add(owusf_pkg::CMD_READ, 8'hFF);
        add(owusf_pkg::CMD_READ, 8'hFF);
        add(owusf_pkg::CMD_READ, 8'hFF);                    // partial byte
        add(owusf_pkg::CMD_BEGIN, 8'h3C);                   // restart drops the partial byte
        add(owusf_pkg::CMD_ECHO, 8'hFF);
        add(owusf_pkg::CMD_READ, 8'hFF);

        // random transactions
        while (pending_reqs.size() < 370) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                add(2'($urandom_range(0, 3)), 8'($urandom));
            end else begin
                add(owusf_pkg::CMD_BEGIN, 8'($urandom));
                if ($urandom_range(0, 7) == 0) begin
                    add(owusf_pkg::CMD_ECHO, owusf_pkg::RESET_FRAME);
                end else begin
                    do
                        echo = 8'($urandom);
                    while (echo == owusf_pkg::RESET_FRAME);
                    add(owusf_pkg::CMD_ECHO, echo);
                    ops = $urandom_range(1, 6);
                    for (int k = 0; k < ops; k++) begin
                        if ($urandom_range(0, 1) == 0) begin
                            add(owusf_pkg::CMD_PAYLOAD, 8'($urandom));
                        end else begin
                            frames = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : SLOTS;
                            for (int f = 0; f < frames; f++) begin
                                pick = $urandom_range(0, 9);
                                add(owusf_pkg::CMD_READ,
                                    (pick < 4) ? owusf_pkg::ONE_FRAME :
                                    (pick < 8) ? owusf_pkg::ZERO_FRAME : 8'($urandom));
                            end
                        end
                    end
                end
            end
        end
        n_total = pending_reqs.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < n_total)
            @(posedge i_clk);
        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        if (n_bad == 0 && frames_due.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
